### hw/rtl/ftr_pkg.sv
// Operation and status codes shared by the transmit ring design.
`timescale 1ns / 1ps

package ftr_pkg;

   typedef logic [1:0] op_type;
   typedef logic [2:0] status_type;

   localparam op_type OP_OFFER = 2'd0;
   localparam op_type OP_BYTE  = 2'd1;
   localparam op_type OP_DONE  = 2'd2;
   localparam op_type OP_READ  = 2'd3;

   localparam status_type ST_ACCEPTED  = 3'd0;
   localparam status_type ST_EMPTY     = 3'd1;
   localparam status_type ST_TOO_LONG  = 3'd2;
   localparam status_type ST_NO_ROOM   = 3'd3;
   localparam status_type ST_STORED    = 3'd4;
   localparam status_type ST_COMMITTED = 3'd5;
   localparam status_type ST_COMPLETED = 3'd6;
   localparam status_type ST_IGNORED   = 3'd7;

endpackage

### hw/rtl/frame_admitting_tx_ring.sv
// Transmit byte ring that admits whole frames and arms drain chunks.
`timescale 1ns / 1ps

// The block takes one command in every clock cycle and never raises busy; each
// command produces exactly one response, shown with rsp_strobe for one cycle, in the
// cycle after the command's transfer. The ring memory has one write port, used for
// the byte write of a frame byte, and a separate read port for the fetch of a read
// command. The receiver cannot hold responses off and must take each one in the
// cycle it appears. Ring entries read before they were ever written return
// undefined data.
module frame_admitting_tx_ring #(
   parameter int RING_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_frame_len,
   input  logic [7:0]  req_data,
   input  logic [9:0]  req_ring_index,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic        rsp_arm_valid,
   output logic [9:0]  rsp_arm_start,
   output logic [10:0] rsp_arm_len,
   output logic [9:0]  rsp_used_bytes,
   output logic        rsp_busy_res,
   output logic [9:0]  rsp_peak_used,
   output logic [31:0] rsp_frames_sent,
   output logic [31:0] rsp_frames_dropped,
   output logic [7:0]  rsp_read_data
);

   localparam int IW = $clog2(RING_BYTES);
   localparam int CW = $clog2(RING_BYTES + 1);
   localparam logic [CW-1:0] RING_C = CW'(RING_BYTES);
   localparam logic [CW-1:0] HALF_C = CW'(RING_BYTES / 2);
   localparam logic [IW-1:0] LAST_C = IW'(RING_BYTES - 1);

   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] fill_ff, fill_in;
   logic [IW-1:0] left_ff, left_in;
   logic          open_ff, open_in;
   logic [CW-1:0] chunk_ff, chunk_in;
   logic          active_ff, active_in;
   logic [IW-1:0] peak_ff, peak_in;
   logic [31:0]   frames_ff, frames_in;
   logic [31:0]   drops_ff, drops_in;

   logic                 accept;
   ftr_pkg::status_type  status;
   logic                 arm_req;
   logic                 armed;
   logic [IW-1:0]        arm_start;
   logic [CW-1:0]        arm_len;
   logic [IW-1:0]        used_cur;
   logic [IW-1:0]        used_new;
   logic [CW-1:0]        fill_inc;
   logic [CW-1:0]        tail_sum;
   logic                 wr_en;
   logic                 rd_en;
   logic                 rd_in_range;
   logic [7:0]           ram_q;

   logic                 rsp_strobe_ff;
   ftr_pkg::status_type  rsp_status_ff;
   logic                 rsp_arm_valid_ff;
   logic [9:0]           rsp_arm_start_ff;
   logic [10:0]          rsp_arm_len_ff;
   logic [9:0]           rsp_used_ff;
   logic                 rsp_busy_res_ff;
   logic [9:0]           rsp_peak_ff;
   logic [31:0]          rsp_frames_ff;
   logic [31:0]          rsp_drops_ff;
   logic                 rsp_read_keep_ff;

   function automatic logic [IW-1:0] ring_used(input logic [IW-1:0] head,
                                               input logic [IW-1:0] tail);
      logic [CW-1:0] wrapped;
      wrapped = RING_C - CW'(tail) + CW'(head);
      if (head >= tail) begin
         return head - tail;
      end
      return IW'(wrapped);
   endfunction

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign used_cur    = ring_used(head_ff, tail_ff);
   assign fill_inc    = CW'(fill_ff) + CW'(1);
   assign tail_sum    = CW'(tail_ff) + chunk_ff;
   assign rd_in_range = {22'd0, req_ring_index} < 32'(RING_BYTES);
   assign rd_en       = accept && (req_op == ftr_pkg::OP_READ) && rd_in_range;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      left_in   = left_ff;
      open_in   = open_ff;
      chunk_in  = chunk_ff;
      active_in = active_ff;
      peak_in   = peak_ff;
      frames_in = frames_ff;
      drops_in  = drops_ff;
      status    = ftr_pkg::ST_IGNORED;
      arm_req   = 1'b0;
      armed     = 1'b0;
      arm_start = '0;
      arm_len   = '0;
      wr_en     = 1'b0;
      case (req_op)
         ftr_pkg::OP_OFFER: begin
            if (!open_ff) begin
               if (req_frame_len == 16'd0) begin
                  status = ftr_pkg::ST_EMPTY;
               end else if (17'(req_frame_len) >= 17'(RING_BYTES)) begin
                  drops_in = drops_ff + 32'd1;
                  status   = ftr_pkg::ST_TOO_LONG;
               end else if (17'(LAST_C - used_cur) < 17'(req_frame_len)) begin
                  drops_in = drops_ff + 32'd1;
                  status   = ftr_pkg::ST_NO_ROOM;
               end else begin
                  open_in = 1'b1;
                  fill_in = head_ff;
                  left_in = IW'(req_frame_len);
                  status  = ftr_pkg::ST_ACCEPTED;
               end
            end
         end
         ftr_pkg::OP_BYTE: begin
            if (open_ff) begin
               wr_en   = 1'b1;
               fill_in = (fill_inc == RING_C) ? '0 : IW'(fill_inc);
               left_in = left_ff - IW'(1);
               if (left_ff == IW'(1)) begin
                  open_in   = 1'b0;
                  head_in   = fill_in;
                  frames_in = frames_ff + 32'd1;
                  arm_req   = 1'b1;
                  status    = ftr_pkg::ST_COMMITTED;
               end else begin
                  status = ftr_pkg::ST_STORED;
               end
            end
         end
         ftr_pkg::OP_DONE: begin
            if (active_ff) begin
               tail_in   = (tail_sum == RING_C) ? '0 : IW'(tail_sum);
               chunk_in  = '0;
               active_in = 1'b0;
               arm_req   = 1'b1;
               status    = ftr_pkg::ST_COMPLETED;
            end
         end
         default: begin
            status = ftr_pkg::ST_IGNORED;
         end
      endcase

      used_new = ring_used(head_in, tail_in);
      if (status == ftr_pkg::ST_COMMITTED && used_new > peak_ff) begin
         peak_in = used_new;
      end
      if (arm_req && !active_in && head_in != tail_in) begin
         armed     = 1'b1;
         arm_start = tail_in;
         arm_len   = (head_in > tail_in) ? CW'(head_in - tail_in) : RING_C - CW'(tail_in);
         chunk_in  = arm_len;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         left_ff       <= '0;
         open_ff       <= 1'b0;
         chunk_ff      <= '0;
         active_ff     <= 1'b0;
         peak_ff       <= '0;
         frames_ff     <= '0;
         drops_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            fill_ff   <= fill_in;
            left_ff   <= left_in;
            open_ff   <= open_in;
            chunk_ff  <= chunk_in;
            active_ff <= active_in;
            peak_ff   <= peak_in;
            frames_ff <= frames_in;
            drops_ff  <= drops_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= status;
         rsp_arm_valid_ff <= armed;
         rsp_arm_start_ff <= 10'(arm_start);
         rsp_arm_len_ff   <= 11'(arm_len);
         rsp_used_ff      <= 10'(used_new);
         rsp_busy_res_ff  <= CW'(used_new) > HALF_C;
         rsp_peak_ff      <= 10'(peak_in);
         rsp_frames_ff    <= frames_in;
         rsp_drops_ff     <= drops_in;
         rsp_read_keep_ff <= rd_en;
      end
   end

   ftr_ram #(
      .WIDTH (8),
      .DEPTH (RING_BYTES)
   ) u_ring (
      .clock      (clock),
      .wr_en      (accept && wr_en),
      .wr_addr    (fill_ff),
      .wr_data    (req_data),
      .rd_en      (rd_en),
      .rd_addr    (IW'(req_ring_index)),
      .rd_data_ff (ram_q)
   );

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_arm_valid      = rsp_arm_valid_ff;
   assign rsp_arm_start      = rsp_arm_start_ff;
   assign rsp_arm_len        = rsp_arm_len_ff;
   assign rsp_used_bytes     = rsp_used_ff;
   assign rsp_busy_res       = rsp_busy_res_ff;
   assign rsp_peak_used      = rsp_peak_ff;
   assign rsp_frames_sent    = rsp_frames_ff;
   assign rsp_frames_dropped = rsp_drops_ff;
   assign rsp_read_data      = rsp_read_keep_ff ? ram_q : 8'd0;

endmodule

### hw/rtl/ftr_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module ftr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
